/* hdl/rlb_pkg.sv */
package rlb_pkg;

  localparam int unsigned ChW = 8;

  // blend_mode register codes
  localparam logic [1:0] ModeMultiply = 2'd0;
  localparam logic [1:0] ModeSubtract = 2'd1;
  localparam logic [1:0] ModeScreen   = 2'd2;
  localparam logic [1:0] ModeOverlay  = 2'd3;

  // Width of the biased product: 2 * 255 * 255 + 127 fits in 17 bits
  localparam int unsigned ProdW = 17;

  // Bias added before the divide so the quotient rounds to nearest
  localparam logic [ProdW-1:0] RoundBias = 17'd127;

  // floor(x / 255) == (x * Div255Recip) >> Div255Shift for every x < 132626
  localparam int unsigned RecipW      = 18;
  localparam logic [RecipW-1:0] Div255Recip = 18'd131587;
  localparam int unsigned Div255Shift = 25;
  localparam int unsigned ScaledW     = ProdW + RecipW;

  // Per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic out;
  } rlb_adv_t;

endpackage

/* hdl/rlb_channel.sv */
module rlb_channel (
  input  logic                      clk_i,
  input  rlb_pkg::rlb_adv_t         adv_i,
  input  logic [1:0]                mode_i,
  input  logic [rlb_pkg::ChW-1:0]   top_i,
  input  logic [rlb_pkg::ChW-1:0]   bottom_i,
  output logic [rlb_pkg::ChW-1:0]   out_o
);

  // Stage 1: operand selection
  logic [rlb_pkg::ChW-1:0] opa_d, opa_q;
  logic [rlb_pkg::ChW-1:0] opb_d, opb_q;
  logic                    dbl_d, dbl_q;
  logic                    inv_d, inv_q;
  logic                    sub_d, sub_q;
  logic [rlb_pkg::ChW-1:0] diff_d, diff_q;
  logic [rlb_pkg::ChW:0]   diff_wide;

  // Stage 2: biased product
  logic [2*rlb_pkg::ChW-1:0]  prod;
  logic [rlb_pkg::ProdW-1:0]  biased_d, biased_q;
  logic                       inv2_q, sub2_q;
  logic [rlb_pkg::ChW-1:0]    diff2_q;

  // Stage 3: scaled by reciprocal of 255
  logic [rlb_pkg::ScaledW-1:0] scaled_d, scaled_q;
  logic                        inv3_q, sub3_q;
  logic [rlb_pkg::ChW-1:0]     diff3_q;

  // Output register
  logic [rlb_pkg::ChW-1:0] quot;
  logic [rlb_pkg::ChW-1:0] out_d, out_q;

  assign diff_wide = {1'b0, bottom_i} - {1'b0, top_i};

  always_comb begin
    opa_d  = top_i;
    opb_d  = bottom_i;
    dbl_d  = 1'b0;
    inv_d  = 1'b0;
    sub_d  = 1'b0;
    // clamp at zero when the top value exceeds the bottom
    diff_d = diff_wide[rlb_pkg::ChW] ? '0 : diff_wide[rlb_pkg::ChW-1:0];
    case (mode_i)
      rlb_pkg::ModeMultiply: begin
      end
      rlb_pkg::ModeSubtract: begin
        sub_d = 1'b1;
      end
      rlb_pkg::ModeScreen: begin
        opa_d = ~top_i;
        opb_d = ~bottom_i;
        inv_d = 1'b1;
      end
      rlb_pkg::ModeOverlay: begin
        dbl_d = 1'b1;
        // bottom above 127 takes the screen-like branch
        if (bottom_i[rlb_pkg::ChW-1]) begin
          opa_d = ~top_i;
          opb_d = ~bottom_i;
          inv_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      opa_q  <= opa_d;
      opb_q  <= opb_d;
      dbl_q  <= dbl_d;
      inv_q  <= inv_d;
      sub_q  <= sub_d;
      diff_q <= diff_d;
    end
  end

  assign prod     = opa_q * opb_q;
  assign biased_d = ({1'b0, prod} << dbl_q) + rlb_pkg::RoundBias;

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      biased_q <= biased_d;
      inv2_q   <= inv_q;
      sub2_q   <= sub_q;
      diff2_q  <= diff_q;
    end
  end

  assign scaled_d = rlb_pkg::ScaledW'(biased_q)
                  * rlb_pkg::ScaledW'(rlb_pkg::Div255Recip);

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      scaled_q <= scaled_d;
      inv3_q   <= inv2_q;
      sub3_q   <= sub2_q;
      diff3_q  <= diff2_q;
    end
  end

  // quotient never exceeds 255 for any mode
  assign quot = scaled_q[rlb_pkg::Div255Shift +: rlb_pkg::ChW];

  always_comb begin
    if (sub3_q) begin
      out_d = diff3_q;
    end else if (inv3_q) begin
      out_d = ~quot;
    end else begin
      out_d = quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.out) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

/* hdl/rgb_layer_blend_unit_top.sv */
// Pipeline: an accepted input item passes the registered stages operand select,
// product, reciprocal scale and output register before output tvalid.
// Throughput: one item per cycle; every stage holds under back-pressure.
// Reset: rst_ni clears all stage valid bits and sets blend_mode to multiply.
module rgb_layer_blend_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write: blend_mode
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // top_red, top_green, top_blue, bottom_red, bottom_green, bottom_blue
  input  logic [47:0] s_axis_tdata_i,
  // output items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_red, out_green, out_blue
  output logic [23:0] m_axis_tdata_o
);

  localparam int unsigned NumCh = 3;
  localparam int unsigned ChW   = rlb_pkg::ChW;

  logic [1:0]        mode_q;
  logic              v1_q, v2_q, v3_q, vout_q;
  rlb_pkg::rlb_adv_t adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rlb_pkg::ModeMultiply;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // a stage loads when it is empty or its content moves on
  assign adv.out = !vout_q || m_axis_tready_i;
  assign adv.s3  = !v3_q || adv.out;
  assign adv.s2  = !v2_q || adv.s3;
  assign adv.s1  = !v1_q || adv.s2;

  assign s_axis_tready_o = adv.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      if (adv.s1) begin
        v1_q <= s_axis_tvalid_i;
      end
      if (adv.s2) begin
        v2_q <= v1_q;
      end
      if (adv.s3) begin
        v3_q <= v2_q;
      end
      if (adv.out) begin
        vout_q <= v3_q;
      end
    end
  end

  for (genvar c = 0; c < NumCh; c++) begin : g_ch
    rlb_channel u_channel (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .mode_i   (mode_q),
      .top_i    (s_axis_tdata_i[c*ChW +: ChW]),
      .bottom_i (s_axis_tdata_i[(c+NumCh)*ChW +: ChW]),
      .out_o    (m_axis_tdata_o[c*ChW +: ChW])
    );
  end

  assign m_axis_tvalid_o = vout_q;

endmodule

/* tb/tb_rgb_layer_blend_unit_top.sv */
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
} rgb_t;

// bottom layer in the upper half, top layer in the lower half of tdata
typedef struct packed {
  rgb_t bottom;
  rgb_t top;
} layer_pair_t;

class blend_scoreboard;
  rgb_t        expected_q[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  // Blend one channel: t from the top layer, b from the bottom layer.
  function automatic logic [7:0] blend_channel(logic [1:0] mode, logic [7:0] t,
                                               logic [7:0] b);
    int unsigned tt;
    int unsigned bb;
    int unsigned r;
    tt = t;
    bb = b;
    case (mode)
      rlb_pkg::ModeMultiply: r = (tt * bb + 127) / 255;
      rlb_pkg::ModeSubtract: r = (bb >= tt) ? bb - tt : 0;
      rlb_pkg::ModeScreen:   r = 255 - ((255 - tt) * (255 - bb) + 127) / 255;
      default: begin
        // overlay: the bottom value picks the multiply or the screen half
        if (bb <= 127) r = (2 * bb * tt + 127) / 255;
        else r = 255 - (2 * (255 - bb) * (255 - tt) + 127) / 255;
      end
    endcase
    return r[7:0];
  endfunction

  function void note_pixel(layer_pair_t p, logic [1:0] mode);
    rgb_t blended;
    blended.red   = blend_channel(mode, p.top.red, p.bottom.red);
    blended.green = blend_channel(mode, p.top.green, p.bottom.green);
    blended.blue  = blend_channel(mode, p.top.blue, p.bottom.blue);
    expected_q.insert(expected_q.size(), blended);
  endfunction

  function void check_pixel(rgb_t got);
    rgb_t want;
    if (expected_q.size() == 0) begin
      $error("unexpected output item %h", got);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.red !== want.red) begin
      $error("out_red: expected %0d, actual %0d", want.red, got.red);
      errors++;
    end
    if (got.green !== want.green) begin
      $error("out_green: expected %0d, actual %0d", want.green, got.green);
      errors++;
    end
    if (got.blue !== want.blue) begin
      $error("out_blue: expected %0d, actual %0d", want.blue, got.blue);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module tb_rgb_layer_blend_unit_top;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned PhaseItems  = 250;
  localparam int unsigned NumPhases   = 8;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i      = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;

  blend_scoreboard blend_sb = new();
  logic [1:0]      blend_mode_q = rlb_pkg::ModeMultiply;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     quiet_cycles = 0;

  rgb_layer_blend_unit_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Track register writes, predict accepted items, check results, watch for hangs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) blend_mode_q = cfg_data_i;
      if (s_axis_tvalid_i && s_axis_tready_o) blend_sb.note_pixel(s_axis_tdata_i, blend_mode_q);
      if (m_axis_tvalid_o && m_axis_tready_i) blend_sb.check_pixel(m_axis_tdata_o);
      if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid_i && s_axis_tready_o) ||
          (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= IdleLimit) begin
        $display("tb_rgb_layer_blend_unit_top: FAIL");
        $finish;
      end
    end
  end

  // Wait for an edge first so the item accepted at the current edge is noted.
  task automatic drain_results();
    @(posedge clk_i);
    while (blend_sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] mode);
    s_axis_tvalid_i <= 1'b0;
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold valid until accepted; drop it only when an idle gap follows.
  task automatic send_pixel(input layer_pair_t p);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= p;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  function automatic logic [7:0] random_channel();
    logic [7:0] corner[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    if ($urandom_range(4) == 0) return corner[$urandom_range(5)];
    return 8'($urandom_range(255));
  endfunction

  function automatic layer_pair_t random_pair();
    layer_pair_t p;
    p.top.red      = random_channel();
    p.top.green    = random_channel();
    p.top.blue     = random_channel();
    p.bottom.red   = random_channel();
    p.bottom.green = random_channel();
    p.bottom.blue  = random_channel();
    return p;
  endfunction

  // Corners per channel: zeros, full scale, overlay branch edges around 127/128.
  function automatic layer_pair_t corner_pair(int idx);
    logic [7:0] top_v[5][3] = '{
      '{8'd0,   8'd255, 8'd0},
      '{8'd255, 8'd127, 8'd128},
      '{8'd1,   8'd254, 8'd200},
      '{8'd128, 8'd0,   8'd255},
      '{8'd255, 8'd255, 8'd255}
    };
    logic [7:0] bot_v[5][3] = '{
      '{8'd0,   8'd255, 8'd255},
      '{8'd0,   8'd127, 8'd128},
      '{8'd127, 8'd128, 8'd255},
      '{8'd128, 8'd127, 8'd129},
      '{8'd0,   8'd0,   8'd0}
    };
    layer_pair_t p;
    p.top    = '{blue: top_v[idx][2], green: top_v[idx][1], red: top_v[idx][0]};
    p.bottom = '{blue: bot_v[idx][2], green: bot_v[idx][1], red: bot_v[idx][0]};
    return p;
  endfunction

  initial begin
    logic [1:0]  phase_mode[NumPhases] = '{
      rlb_pkg::ModeOverlay, rlb_pkg::ModeMultiply, rlb_pkg::ModeScreen, rlb_pkg::ModeSubtract,
      rlb_pkg::ModeSubtract, rlb_pkg::ModeOverlay, rlb_pkg::ModeMultiply, rlb_pkg::ModeScreen
    };
    int unsigned idle_pct[4]  = '{0, 65, 0, 31};
    int unsigned stall_pct[4] = '{0, 0, 65, 31};
    logic [1:0]  all_modes[4] = '{
      rlb_pkg::ModeMultiply, rlb_pkg::ModeSubtract, rlb_pkg::ModeScreen, rlb_pkg::ModeOverlay
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (all_modes[m]) begin
      write_mode(all_modes[m]);
      for (int i = 0; i < 5; i++) send_pixel(corner_pair(i));
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      send_idle_pct  = idle_pct[ph % 4];
      recv_stall_pct = stall_pct[ph % 4];
      write_mode(phase_mode[ph]);
      for (int i = 0; i < PhaseItems; i++) begin
        if (ph == 3 && i == PhaseItems / 2) begin
          // hold off the sender until the pipeline has emptied
          s_axis_tvalid_i <= 1'b0;
          drain_results();
        end
        send_pixel(random_pair());
      end
    end

    s_axis_tvalid_i <= 1'b0;
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (blend_sb.errors == 0 && blend_sb.pending() == 0) begin
      $display("tb_rgb_layer_blend_unit_top: PASS");
    end else begin
      $display("tb_rgb_layer_blend_unit_top: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/rlb_pkg.sv
hdl/rlb_channel.sv
hdl/rgb_layer_blend_unit_top.sv
tb/tb_rgb_layer_blend_unit_top.sv
